[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, off while reset is high.
`define PSRE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define PSRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/psre_pkg.sv]
package psre_pkg;

   localparam int PATTERN_DEPTH = 64;
   localparam int ADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int IDX_W = 6;
   localparam int LEN_W = 7;
   localparam int WORD_W = 32;
   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'((PATTERN_DEPTH < 64) ? PATTERN_DEPTH : 64);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_PIXEL = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_1BPP  = 3'd0,
      MODE_4BPP  = 3'd1,
      MODE_8BPP  = 3'd2,
      MODE_16BPP = 3'd3,
      MODE_24BPP = 3'd4,
      MODE_32BPP = 3'd5
   } depth_mode_type;

   localparam logic [1:0] CSR_DEPTH_MODE = 2'd0;
   localparam logic [1:0] CSR_PATTERN_LEN = 2'd1;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] and_value;
      logic [WORD_W-1:0] xor_value;
   } store_wr_type;

   typedef struct packed {
      logic              valid;
      logic              zero_entry;
      logic [IDX_W-1:0]  used;
      logic [2:0]        pos;
      logic [WORD_W-1:0] dest;
   } pix_stage_type;

   function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] v);
      logic [ADDR_W+IDX_W-1:0] ext;
      ext = {{ADDR_W{1'b0}}, v};
      return ext[ADDR_W-1:0];
   endfunction

   function automatic logic in_store(input logic [IDX_W-1:0] v);
      return {{(32-IDX_W){1'b0}}, v} < 32'(PATTERN_DEPTH);
   endfunction

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] l;
      l = (len == '0) ? LEN_W'(1) : len;
      if (l > LEN_CAP) begin
         l = LEN_CAP;
      end
      return l;
   endfunction

endpackage

[rtl/psre_pattern_store.sv]
module psre_pattern_store
   import psre_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_and,
   output logic [WORD_W-1:0] rd_xor
);

   logic [WORD_W-1:0] and_store_ff [PATTERN_DEPTH];
   logic [WORD_W-1:0] xor_store_ff [PATTERN_DEPTH];
   logic [WORD_W-1:0] rd_and_ff;
   logic [WORD_W-1:0] rd_xor_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         and_store_ff[wr.addr] <= wr.and_value;
         xor_store_ff[wr.addr] <= wr.xor_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_and_ff <= and_store_ff[rd_addr];
         rd_xor_ff <= xor_store_ff[rd_addr];
      end
   end

   assign rd_and = rd_and_ff;
   assign rd_xor = rd_xor_ff;

endmodule

[rtl/psre_rop_stage.sv]
`include "assert_macros.svh"

module psre_rop_stage
   import psre_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pix_stage_type     pix,
   input  logic [WORD_W-1:0] and_entry,
   input  logic [WORD_W-1:0] xor_entry,
   input  logic [2:0]        depth_mode,
   output logic              pix_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_new_dest_value,
   output logic [IDX_W-1:0]  rsp_entry_used
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]  used_ff;
   logic [WORD_W-1:0] a, x, a_rep, x_rep, m;

   assign pix_take = pix.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      a = pix.zero_entry ? '0 : and_entry;
      x = pix.zero_entry ? '0 : xor_entry;
      a_rep = a;
      x_rep = x;
      case (depth_mode)
         MODE_1BPP: begin
            m = {24'd0, 8'h80 >> pix.pos};
            a_rep = {WORD_W{a[0]}};
            x_rep = {WORD_W{x[0]}};
         end
         MODE_4BPP: begin
            m = pix.pos[0] ? 32'h0000_000f : 32'h0000_00f0;
            a_rep = {8{a[3:0]}};
            x_rep = {8{x[3:0]}};
         end
         MODE_8BPP:  m = 32'h0000_00ff;
         MODE_16BPP: m = 32'h0000_ffff;
         MODE_24BPP: m = 32'h00ff_ffff;
         MODE_32BPP: m = 32'hffff_ffff;
         default:    m = '0;
      endcase
      value_in = (pix.dest & (a_rep | ~m)) ^ (x_rep & m);
   end

   always_comb begin
      if (pix_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take) begin
         value_ff <= value_in;
         used_ff  <= pix.used;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_dest_value = value_ff;
   assign rsp_entry_used     = used_ff;

   `PSRE_ASSERT_NEXT(a_take_fills_rsp, pix_take, rsp_valid_ff, "taken pixel did not reach output")
   `PSRE_ASSERT(a_take_only_valid, !pix_take || pix.valid, "stage taken without a pixel")

endmodule

[rtl/pattern_span_rop_engine_unit.sv]
// Flow: an accepted pixel word is registered into the pixel stage along
//   with the pattern store read, then into the rsp output register.
// Throughput: one word per cycle while rsp_stall is low; the pattern store's
//   registered read port and the single output register set that figure.
// Reset: synchronous, active high; clears the span offset, the valid flags,
//   depth mode to 8 bpp and pattern length to 1. Pattern entries hold
//   whatever was loaded and are undefined until written.
`include "assert_macros.svh"

module pattern_span_rop_engine_unit
   import psre_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // configuration port
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [LEN_W-1:0]  csr_wdata,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [IDX_W-1:0]  req_entry_index,
   input  logic [WORD_W-1:0] req_and_value,
   input  logic [WORD_W-1:0] req_xor_value,
   input  logic [IDX_W-1:0]  req_span_offset,
   input  logic [2:0]        req_pixel_in_word,
   input  logic [WORD_W-1:0] req_dest_value,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_new_dest_value,
   output logic [IDX_W-1:0]  rsp_entry_used
);

   // Configuration registers.
   logic [2:0]       mode_ff;
   logic [LEN_W-1:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_8BPP;
         len_ff  <= LEN_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEPTH_MODE:  mode_ff <= csr_wdata[2:0];
            CSR_PATTERN_LEN: len_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request acceptance. A word is taken unless the pixel stage holds one
   // that cannot move into the output register this cycle.
   logic             accept, load_acc, start_acc, pixel_acc;
   logic             pix_take;
   pix_stage_type    pix_ff, pix_in;
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] step;
   logic [IDX_W-1:0] offset_ff, offset_in;
   store_wr_type     store_wr;
   logic [WORD_W-1:0] rd_and, rd_xor;

   assign req_stall = pix_ff.valid && !pix_take;
   assign accept    = req_valid && !req_stall;
   assign load_acc  = accept && (req_opcode == OP_LOAD);
   assign start_acc = accept && (req_opcode == OP_START);
   assign pixel_acc = accept && (req_opcode == OP_PIXEL);

   assign len_eff = eff_len(len_ff);
   assign step    = {1'b0, offset_ff} + LEN_W'(1);

   // Span offset: set by a start word (clamp to 0 past the length),
   // advance on each pixel and wrap at the length.
   always_comb begin
      offset_in = offset_ff;
      if (start_acc) begin
         offset_in = ({1'b0, req_span_offset} < len_eff) ? req_span_offset : '0;
      end else if (pixel_acc) begin
         offset_in = (step >= len_eff) ? '0 : step[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   // Pattern load: drop indexes that fall outside the store.
   always_comb begin
      store_wr.en        = load_acc && in_store(req_entry_index);
      store_wr.addr      = to_addr(req_entry_index);
      store_wr.and_value = req_and_value;
      store_wr.xor_value = req_xor_value;
   end

   psre_pattern_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (pixel_acc),
      .rd_addr (to_addr(offset_ff)),
      .rd_and  (rd_and),
      .rd_xor  (rd_xor)
   );

   // Pixel stage: hold the word's metadata alongside the store read.
   always_comb begin
      pix_in.valid      = pixel_acc ? 1'b1 : (pix_take ? 1'b0 : pix_ff.valid);
      pix_in.zero_entry = !in_store(offset_ff);
      pix_in.used       = offset_ff;
      pix_in.pos        = req_pixel_in_word;
      pix_in.dest       = req_dest_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff.valid <= 1'b0;
      end else begin
         pix_ff.valid <= pix_in.valid;
      end
      if (pixel_acc) begin
         pix_ff.zero_entry <= pix_in.zero_entry;
         pix_ff.used       <= pix_in.used;
         pix_ff.pos        <= pix_in.pos;
         pix_ff.dest       <= pix_in.dest;
      end
   end

   psre_rop_stage u_rop (
      .clock              (clock),
      .reset              (reset),
      .pix                (pix_ff),
      .and_entry          (rd_and),
      .xor_entry          (rd_xor),
      .depth_mode         (mode_ff),
      .pix_take           (pix_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_new_dest_value (rsp_new_dest_value),
      .rsp_entry_used     (rsp_entry_used)
   );

   `PSRE_ASSERT_NEXT(a_pixel_enters_stage, pixel_acc, pix_ff.valid, "accepted pixel lost")
   `PSRE_ASSERT_NEXT(a_start_in_range, start_acc,
                     ({1'b0, offset_ff} < $past(len_eff)), "start offset past length")
   `PSRE_ASSERT_NEXT(a_offset_idle,
                     (accept && (req_opcode == OP_LOAD || req_opcode == OP_NONE)),
                     (offset_ff == $past(offset_ff)), "offset moved on a non-span word")

endmodule
